### hw/rtl/ethernet_split_filter_classifier_assert.svh
// Assertion macros for the frame classifier
`ifndef ETHERNET_SPLIT_FILTER_CLASSIFIER_ASSERT_SVH
`define ETHERNET_SPLIT_FILTER_CLASSIFIER_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define ESFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("classifier check failed");

// antecedent holds -> consequent in the next cycle
`define ESFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("classifier check failed");

`endif

### hw/rtl/esfc_pkg.sv
// Types and constants of the Ethernet split-filter classifier
`timescale 1ns / 1ps
package esfc_pkg;

	typedef enum logic [1:0] {
		VERDICT_NONE   = 2'd0,
		VERDICT_BOTH   = 2'd1,
		VERDICT_CLIENT = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		REG_ATALK_ENABLE   = 3'd0,
		REG_ATALK_CHECK    = 3'd1,
		REG_ATALK_NET      = 3'd2,
		REG_ATALK_NODE     = 3'd3,
		REG_IP_ENABLE      = 3'd4,
		REG_IP_CHECK       = 3'd5,
		REG_IP_ADDRESS     = 3'd6
	} reg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CNT_W      = 6;

	localparam logic [CNT_W-1:0] CAPTURE_LEN   = 6'd34;
	// frame shorter than 32 bytes: byte index of the last byte below 31
	localparam logic [CNT_W-1:0] LAST_IDX_MIN  = 6'd31;

	localparam logic [15:0] MAX_LENGTH_FIELD = 16'd1500;
	localparam logic [15:0] LLC_SNAP         = 16'haaaa;
	localparam logic [31:0] OUI_DDP          = 32'h0308_0007;
	localparam logic [15:0] PROTO_DDP        = 16'h809b;
	localparam logic [31:0] OUI_AARP         = 32'h0300_0000;
	localparam logic [15:0] PROTO_AARP       = 16'h80f3;
	localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
	localparam logic [15:0] ETYPE_ARP        = 16'h0806;

	typedef struct packed {
		logic        group_bit;
		logic [15:0] length_or_type;
		logic [15:0] llc_dsap_ssap;
		logic [31:0] snap_control_oui;
		logic [15:0] snap_protocol;
		logic [15:0] ddp_dest_net;
		logic [7:0]  ddp_dest_node;
		logic [31:0] ipv4_dest;
	} capture_t;

	typedef struct packed {
		logic        atalk_enable;
		logic        atalk_check_address;
		logic [15:0] atalk_net;
		logic [7:0]  atalk_node;
		logic        ip_enable;
		logic        ip_check_address;
		logic [31:0] ip_address;
	} cfg_t;

endpackage

### hw/rtl/ethernet_split_filter_classifier.sv
// Ethernet split-filter classifier: byte capture and per-frame verdict
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   frame_byte, end_of_frame
//   out      out  out_valid / out_ready verdict
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained, but a last byte waits in the input register
// while both result entries are full; a byte goes from the input register to
// the capture registers, and a last byte's verdict to the result buffer.
// A two-entry result buffer lets bytes flow while a verdict waits.
// Reset clears configuration, capture state and all valid flags.
// cfg_ready is always high.
`timescale 1ns / 1ps
module ethernet_split_filter_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          frame_byte,
	input  logic                                end_of_frame,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          verdict,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [esfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [esfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "ethernet_split_filter_classifier_assert.svh"

	esfc_pkg::cfg_t cfg_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	logic [esfc_pkg::CNT_W-1:0] byte_count_q;
	esfc_pkg::capture_t         cap_q;
	esfc_pkg::capture_t         cap_nxt;
	esfc_pkg::verdict_t         decide;

	logic               out_valid_q;
	esfc_pkg::verdict_t verdict_q;
	logic               skid_valid_q;
	esfc_pkg::verdict_t skid_verdict_q;

	logic go_s1;
	logic push;
	logic pop;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				esfc_pkg::REG_ATALK_ENABLE: cfg_q.atalk_enable        <= cfg_data[0];
				esfc_pkg::REG_ATALK_CHECK:  cfg_q.atalk_check_address <= cfg_data[0];
				esfc_pkg::REG_ATALK_NET:    cfg_q.atalk_net           <= cfg_data[15:0];
				esfc_pkg::REG_ATALK_NODE:   cfg_q.atalk_node          <= cfg_data[7:0];
				esfc_pkg::REG_IP_ENABLE:    cfg_q.ip_enable           <= cfg_data[0];
				esfc_pkg::REG_IP_CHECK:     cfg_q.ip_check_address    <= cfg_data[0];
				esfc_pkg::REG_IP_ADDRESS:   cfg_q.ip_address          <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign go_s1    = valid_s1 && (!eof_s1 || !skid_valid_q);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			eof_s1  <= end_of_frame;
		end
	end

	// header capture with the current beat merged in
	always_comb begin
		cap_nxt = cap_q;
		unique case (byte_count_q)
			6'd0:  cap_nxt.group_bit              = byte_s1[0];
			6'd12: cap_nxt.length_or_type[15:8]   = byte_s1;
			6'd13: cap_nxt.length_or_type[7:0]    = byte_s1;
			6'd14: cap_nxt.llc_dsap_ssap[15:8]    = byte_s1;
			6'd15: cap_nxt.llc_dsap_ssap[7:0]     = byte_s1;
			6'd16: cap_nxt.snap_control_oui[31:24] = byte_s1;
			6'd17: cap_nxt.snap_control_oui[23:16] = byte_s1;
			6'd18: cap_nxt.snap_control_oui[15:8]  = byte_s1;
			6'd19: cap_nxt.snap_control_oui[7:0]   = byte_s1;
			6'd20: cap_nxt.snap_protocol[15:8]    = byte_s1;
			6'd21: cap_nxt.snap_protocol[7:0]     = byte_s1;
			6'd26: cap_nxt.ddp_dest_net[15:8]     = byte_s1;
			6'd27: cap_nxt.ddp_dest_net[7:0]      = byte_s1;
			6'd30: begin
				cap_nxt.ddp_dest_node    = byte_s1;
				cap_nxt.ipv4_dest[31:24] = byte_s1;
			end
			6'd31: cap_nxt.ipv4_dest[23:16] = byte_s1;
			6'd32: cap_nxt.ipv4_dest[15:8]  = byte_s1;
			6'd33: cap_nxt.ipv4_dest[7:0]   = byte_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			cap_q        <= '0;
		end else if (go_s1) begin
			if (eof_s1) begin
				byte_count_q <= '0;
				cap_q        <= '0;
			end else begin
				cap_q <= cap_nxt;
				if (byte_count_q < esfc_pkg::CAPTURE_LEN) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
			end
		end
	end

	// verdict
	always_comb begin
		decide = esfc_pkg::VERDICT_NONE;
		if (byte_count_q < esfc_pkg::LAST_IDX_MIN) begin
			decide = esfc_pkg::VERDICT_NONE;
		end else if (cap_nxt.group_bit) begin
			decide = esfc_pkg::VERDICT_BOTH;
		end else if (!cfg_q.atalk_enable && !cfg_q.ip_enable) begin
			decide = esfc_pkg::VERDICT_BOTH;
		end else if (cfg_q.atalk_enable &&
				cap_nxt.length_or_type <= esfc_pkg::MAX_LENGTH_FIELD) begin
			if (cap_nxt.llc_dsap_ssap != esfc_pkg::LLC_SNAP) begin
				decide = esfc_pkg::VERDICT_NONE;
			end else if (cap_nxt.snap_control_oui == esfc_pkg::OUI_DDP &&
					cap_nxt.snap_protocol == esfc_pkg::PROTO_DDP) begin
				if (!cfg_q.atalk_check_address ||
						(cap_nxt.ddp_dest_net == cfg_q.atalk_net &&
						cap_nxt.ddp_dest_node == cfg_q.atalk_node)) begin
					decide = esfc_pkg::VERDICT_CLIENT;
				end
			end else if (cap_nxt.snap_control_oui == esfc_pkg::OUI_AARP &&
					cap_nxt.snap_protocol == esfc_pkg::PROTO_AARP) begin
				decide = esfc_pkg::VERDICT_BOTH;
			end
		end else if (cfg_q.ip_enable &&
				cap_nxt.length_or_type > esfc_pkg::MAX_LENGTH_FIELD) begin
			if (cap_nxt.length_or_type == esfc_pkg::ETYPE_IPV4) begin
				if (!cfg_q.ip_check_address || cap_nxt.ipv4_dest == cfg_q.ip_address) begin
					decide = esfc_pkg::VERDICT_CLIENT;
				end
			end else if (cap_nxt.length_or_type == esfc_pkg::ETYPE_ARP) begin
				decide = esfc_pkg::VERDICT_BOTH;
			end
		end
	end

	// two-entry result buffer
	assign push = go_s1 && eof_s1;
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				verdict_q <= skid_verdict_q;
				if (push) begin
					skid_verdict_q <= decide;
				end
			end else if (push) begin
				verdict_q <= decide;
			end
		end else if (push) begin
			skid_verdict_q <= decide;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	`ESFC_ASSERT_NOW(a_skid_needs_head, clk, arst_n, skid_valid_q, out_valid_q)
	`ESFC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, byte_count_q <= esfc_pkg::CAPTURE_LEN)
	`ESFC_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !skid_valid_q)
	`ESFC_ASSERT_NEXT(a_frame_restart, clk, arst_n, push, byte_count_q == '0)

endmodule
